@@ hw/rtl/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and helper functions for the XTEA encrypt pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int          WordW         = 32;
  localparam int          KeyWords      = 4;
  localparam int          KeyIdxW       = 2;
  localparam int          CfgIdxW       = 8;
  localparam int          DefRoundCount = 32;
  localparam logic [31:0] XteaDelta     = 32'h9e37_79b9;

  typedef logic [WordW-1:0]                 word_t;
  typedef logic [KeyWords-1:0][WordW-1:0]   key_t;

  // Register map of the config port
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD0 = 8'd0,
    REG_KEY_WORD1 = 8'd1,
    REG_KEY_WORD2 = 8'd2,
    REG_KEY_WORD3 = 8'd3
  } cfg_reg_t;

  // Running sum after n additions of delta (mod 2^32); elaboration only
  function automatic word_t xtea_sum(input int n);
    logic [63:0] prod;
    begin
      prod = 64'(n) * 64'(XteaDelta);
      return prod[WordW-1:0];
    end
  endfunction

  // Feistel mixing term
  function automatic word_t xtea_mix(input word_t w);
    begin
      return ((w << 4) ^ (w >> 5)) + w;
    end
  endfunction

endpackage

@@ hw/rtl/xtea_half_round.sv @@
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered Feistel half-round; the round sum is fixed per stage.
// ----------------------------------------------------------------------------
module xtea_half_round import xtea_pkg::*; #(
  parameter bit          UPDATE_Z = 1'b0,
  parameter logic [31:0] SUM      = 32'h0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  key_t  key,
  input  logic  in_v,
  input  word_t in_y,
  input  word_t in_z,
  output logic  out_v,
  output word_t out_y,
  output word_t out_z
);

  // Key word picked by the stage's constant sum
  localparam logic [KeyIdxW-1:0] KeySel =
    UPDATE_Z ? SUM[12:11] : SUM[KeyIdxW-1:0];

  logic  v_r;
  word_t y_r, z_r;
  word_t y_nxt, z_nxt;
  word_t rkey;

  assign rkey = SUM + key[KeySel];

  // Half-round datapath
  always_comb begin
    y_nxt = in_y;
    z_nxt = in_z;
    if (UPDATE_Z) begin
      z_nxt = in_z + (xtea_mix(in_y) ^ rkey);
    end else begin
      y_nxt = in_y + (xtea_mix(in_z) ^ rkey);
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_v = v_r;
  assign out_y = y_r;
  assign out_z = z_r;

endmodule

@@ hw/rtl/xtea_out_buf.sv @@
// ----------------------------------------------------------------------------
// XTEA output buffer
// Two-entry result queue; its room flag drives the pipeline advance.
// ----------------------------------------------------------------------------
module xtea_out_buf import xtea_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  word_t push_y,
  input  word_t push_z,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_y,
  output word_t out_z
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  word_t      y_r [2];
  word_t      z_r [2];
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_y     = y_r[rd_ptr_r];
  assign out_z     = z_r[rd_ptr_r];

  // Fill count
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      y_r[wr_ptr_r] <= push_y;
      z_r[wr_ptr_r] <= push_z;
    end
  end

endmodule

@@ hw/rtl/xtea_block_encrypt.sv @@
// A request goes through the half-round stage registers, then the output queue.
// Throughput: one block per cycle while the two-entry output queue has room;
// each half-round is one stage; all stages hold while the queue is full.
// Reset (rst_n, synchronous, active low) clears all valids and the key to zero.
// ----------------------------------------------------------------------------
// XTEA block encrypt
// Fully unrolled XTEA encipher pipeline with a key set through a write port.
// ----------------------------------------------------------------------------
module xtea_block_encrypt import xtea_pkg::*; #(
  parameter int ROUND_COUNT = DefRoundCount
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WordW-1:0]   in_block_first_word,
  input  logic [WordW-1:0]   in_block_second_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WordW-1:0]   out_cipher_first_word,
  output logic [WordW-1:0]   out_cipher_second_word
);

  localparam int NumStages = 2 * ROUND_COUNT;

  key_t  key_r;
  logic  adv;
  logic  stg_v [NumStages+1];
  word_t stg_y [NumStages+1];
  word_t stg_z [NumStages+1];

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_WORD0: key_r[0] <= cfg_wdata;
        REG_KEY_WORD1: key_r[1] <= cfg_wdata;
        REG_KEY_WORD2: key_r[2] <= cfg_wdata;
        REG_KEY_WORD3: key_r[3] <= cfg_wdata;
        default:       key_r    <= key_r;
      endcase
    end
  end

  // Pipeline entry
  assign in_ready = adv;
  assign stg_v[0] = in_valid && adv;
  assign stg_y[0] = in_block_first_word;
  assign stg_z[0] = in_block_second_word;

  // Half-round stages
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    xtea_half_round #(
      .UPDATE_Z (1'(k % 2)),
      .SUM      (xtea_sum((k / 2) + (k % 2)))
    ) u_hr (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .key   (key_r),
      .in_v  (stg_v[k]),
      .in_y  (stg_y[k]),
      .in_z  (stg_z[k]),
      .out_v (stg_v[k+1]),
      .out_y (stg_y[k+1]),
      .out_z (stg_z[k+1])
    );
  end

  // Result queue
  xtea_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stg_v[NumStages] && adv),
    .push_y    (stg_y[NumStages]),
    .push_z    (stg_z[NumStages]),
    .room      (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_y     (out_cipher_first_word),
    .out_z     (out_cipher_second_word)
  );

endmodule

@@ hw/rtl/xtea_checker.sv @@
// ----------------------------------------------------------------------------
// XTEA port checker
// Concurrent checks on the top-level ports, bound to the encrypt block.
// ----------------------------------------------------------------------------
module xtea_checker import xtea_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WordW-1:0] out_cipher_first_word,
  input logic [WordW-1:0] out_cipher_second_word
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_first_word)
      && $stable(out_cipher_second_word))
    else $error("result changed while stalled");

  // Input back-pressure only with results queued
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid right after reset");

  // Input is never blocked the cycle after a result is taken
  a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready)
    else $error("in_ready low after result taken");

endmodule

bind xtea_block_encrypt xtea_checker u_xtea_checker (.*);

@@ dv/tb_xtea_block_encrypt.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XTEA block encrypt testbench
// Sends plaintext blocks through the encrypt pipeline under a series of keys,
// predicts each ciphertext with a behavioral encipher loop and compares every
// result in order, with random idle cycles on both handshake sides.
// ----------------------------------------------------------------------------
module tb_xtea_block_encrypt;
  import xtea_pkg::*;

  localparam int ROUNDS       = DefRoundCount;
  localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;
  localparam int PHASE_COUNT  = 7;
  localparam int PHASE_ITEMS  = 100;

  // Register indexes past the key map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_IDX_PAST_KEY = CfgIdxW'(KeyWords);
  localparam logic [CfgIdxW-1:0] CFG_IDX_TOP      = '1;

  typedef struct packed {
    word_t first;
    word_t second;
  } cipher_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WordW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [WordW-1:0]   in_block_first_word = '0;
  logic [WordW-1:0]   in_block_second_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WordW-1:0]   out_cipher_first_word;
  logic [WordW-1:0]   out_cipher_second_word;

  word_t       key_reg [KeyWords];
  cipher_t     expected_cipher [$];
  int unsigned mismatch_count = 0;
  bit          no_idle = 1'b0;
  int unsigned sink_stall_left = 0;

  xtea_block_encrypt DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_block_first_word    (in_block_first_word),
    .in_block_second_word   (in_block_second_word),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_cipher_first_word  (out_cipher_first_word),
    .out_cipher_second_word (out_cipher_second_word)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Behavioral encipher under the current key
  function automatic cipher_t xtea_encipher(word_t y, word_t z);
    word_t   total;
    int      r;
    cipher_t res;
    total = '0;
    for (r = 0; r < ROUNDS; r++) begin
      y = y + ((((z << 4) ^ (z >> 5)) + z) ^ (total + key_reg[total[1:0]]));
      total = total + XteaDelta;
      z = z + ((((y << 4) ^ (y >> 5)) + y) ^ (total + key_reg[total[12:11]]));
    end
    res.first  = y;
    res.second = z;
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Data word biased toward the edges
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WordW - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WordW - 1));
      default: return $urandom;
    endcase
  endfunction

  // Send one request; returns at the edge where it is taken
  task automatic send_block(input word_t y, input word_t z);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_block_first_word  <= y;
    in_block_second_word <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_cipher.push_back(xtea_encipher(y, z));
  endtask

  // Stop requesting and wait for every pending result
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cipher.size() != 0) @(posedge clk);
  endtask

  // One register write; only called with the pipeline empty
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < KeyWords) key_reg[idx[KeyIdxW-1:0]] = data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_key(input word_t k0, input word_t k1, input word_t k2,
                           input word_t k3);
    write_reg(REG_KEY_WORD0, k0);
    write_reg(REG_KEY_WORD1, k1);
    write_reg(REG_KEY_WORD2, k2);
    write_reg(REG_KEY_WORD3, k3);
  endtask

  // Edge blocks before any key write: the key is all zero
  task automatic test_reset_key();
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hffff_ffff, 32'hffff_ffff);
    send_block(32'h0000_0000, 32'hffff_ffff);
    send_block(32'hffff_ffff, 32'h0000_0000);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'ha5a5_a5a5, 32'h5a5a_5a5a);
    wait_drain();
  endtask

  // All-ones key, then distinct words so a swapped key word shows up
  task automatic test_key_extremes();
    write_key('1, '1, '1, '1);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hffff_ffff, 32'hffff_ffff);
    send_block(32'h7fff_ffff, 32'hffff_fffe);
    wait_drain();
    write_key(32'h0302_0100, 32'h0706_0504, 32'h0b0a_0908, 32'h0f0e_0d0c);
    send_block(32'h4142_4344, 32'h4546_4748);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hdead_beef, 32'h0123_4567);
    wait_drain();
  endtask

  // Writes past the key map must leave the key alone
  task automatic test_unmapped_index();
    write_reg(CFG_IDX_PAST_KEY, $urandom);
    write_reg(CFG_IDX_TOP, '1);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'h1234_5678, 32'h9abc_def0);
    send_block(32'hffff_ffff, 32'h0000_0000);
    wait_drain();
  endtask

  // Random blocks under a sequence of keys, with a mid-phase pause
  task automatic test_random_traffic();
    int   phase;
    int   n;
    int   k;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drain();
      no_idle = (phase == 3);
      case (phase % 3)
        0: write_key($urandom, $urandom, $urandom, $urandom);
        1: write_key(pick_word(), pick_word(), pick_word(), pick_word());
        default: begin
          k = $urandom_range(0, KeyWords - 1);
          write_reg(cfg_reg_t'(k), pick_word());
          write_reg(CfgIdxW'($urandom_range(KeyWords, 255)), $urandom);
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drain();
        send_block(pick_word(), pick_word());
      end
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Result side: ready with random stalls
  always @(negedge clk) begin
    if (sink_stall_left != 0) begin
      out_ready <= 1'b0;
      sink_stall_left = sink_stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      sink_stall_left = pick_gap();
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    cipher_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cipher.size() == 0) begin
        $display("%0t: unexpected result first=%h second=%h", $time,
                 out_cipher_first_word, out_cipher_second_word);
        mismatch_count++;
      end else begin
        want = expected_cipher.pop_front();
        if (out_cipher_first_word !== want.first) begin
          $display("%0t: cipher_first_word expected %h actual %h", $time,
                   want.first, out_cipher_first_word);
          mismatch_count++;
        end
        if (out_cipher_second_word !== want.second) begin
          $display("%0t: cipher_second_word expected %h actual %h", $time,
                   want.second, out_cipher_second_word);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    foreach (key_reg[i]) key_reg[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_key();
    test_key_extremes();
    test_unmapped_index();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
